### design/mpr_pkg.sv
// Package for the masked pixel to RGB888 converter.
// Holds shared widths, register indexes and the structs passed between modules.
// No dependencies.
package mpr_pkg;

    // Fixed field widths.
    localparam int MASK_W    = 32;
    localparam int OUT_W     = 8;
    localparam int SHIFT_W   = 5;
    localparam int ADDR_W    = 4;
    localparam int NUM_CH    = 3;

    // Pipeline shape: capture, mask, align, numerator, then one quotient bit per stage.
    localparam int DIV_STEPS = OUT_W;
    localparam int NSTG      = 4 + DIV_STEPS;

    // Stage numbers of the front of the pipeline.
    localparam int STG_PIX   = 0;
    localparam int STG_MSK   = 1;
    localparam int STG_VAL   = 2;
    localparam int STG_NUM   = 3;
    localparam int STG_DIV   = 4;

    // Register indexes, decoded from paddr[3:2].
    localparam logic [1:0] REG_RED   = 2'd0;
    localparam logic [1:0] REG_GREEN = 2'd1;
    localparam logic [1:0] REG_BLUE  = 2'd2;

    // Per-channel configuration derived from a mask register.
    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic [SHIFT_W-1:0] shift;
        logic [MASK_W-1:0]  maximum;
        logic               zero;
    } t_chan_cfg;

    // Stage control shared by all channel datapaths.
    typedef struct packed {
        logic [NSTG-1:0] load;
        logic [NSTG-1:0] vld;
    } t_pipe_ctl;

endpackage

### design/mpr_cfg.sv
// Configuration registers of the converter: APB-style access to the three masks
// and the per-channel shift, maximum and zero flag derived from them.
// Depends on mpr_pkg.
module mpr_cfg
    import mpr_pkg::*;
#(
    parameter int PIXEL_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [MASK_W-1:0] pwdata,
    output logic [MASK_W-1:0] prdata,
    output logic              pready,
    output t_chan_cfg         o_cfg [NUM_CH]
);

    localparam int DW = (PIXEL_BITS < MASK_W) ? PIXEL_BITS : MASK_W;
    localparam logic [MASK_W-1:0] WMASK = {MASK_W{1'b1}} >> (MASK_W - DW);

    logic [MASK_W-1:0] r_mask [NUM_CH];
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // Mask registers; writes beyond the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask[0] <= 32'h00FF_0000;
            r_mask[1] <= 32'h0000_FF00;
            r_mask[2] <= 32'h0000_00FF;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_RED:   r_mask[0] <= pwdata;
                REG_GREEN: r_mask[1] <= pwdata;
                REG_BLUE:  r_mask[2] <= pwdata;
                default:   ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[3:2])
            REG_RED:   prdata = r_mask[0];
            REG_GREEN: prdata = r_mask[1];
            REG_BLUE:  prdata = r_mask[2];
            default:   prdata = '0;
        endcase
    end

    // Shift and zero are registered from the mask; the maximum uses the registered shift.
    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        logic [MASK_W-1:0]  w_emask;
        logic [SHIFT_W-1:0] n_shift;
        logic [SHIFT_W-1:0] r_shift;
        logic [MASK_W-1:0]  r_max;
        logic               r_zero;

        assign w_emask = r_mask[c] & WMASK;

        // Position of the lowest set mask bit.
        always_comb begin
            n_shift = '0;
            for (int i = DW - 1; i >= 0; i--) begin
                if (w_emask[i]) begin
                    n_shift = SHIFT_W'(i);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_shift <= n_shift;
            r_zero  <= (w_emask == '0);
            r_max   <= MASK_W'(w_emask[DW-1:0] >> r_shift);
        end

        assign o_cfg[c].mask    = w_emask;
        assign o_cfg[c].shift   = r_shift;
        assign o_cfg[c].maximum = r_max;
        assign o_cfg[c].zero    = r_zero;
    end

endmodule

### design/mpr_ctl.sv
// Valid pipeline and per-stage load enables for the converter.
// A stage loads when it is empty or the stage after it moves on, so bubbles collapse.
// Depends on mpr_pkg.
module mpr_ctl
    import mpr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  logic      i_ready,
    output t_pipe_ctl o_ctl
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_load;

    // A stage can load unless it and every stage after it are full and the output stalls.
    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            w_load[k] = i_ready || ((r_vld | NSTG'((1 << k) - 1)) != {NSTG{1'b1}});
        end
    end

    // Valid bits move with the data.
    always_comb begin
        n_vld = r_vld;
        if (w_load[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_load[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready     = w_load[0];
    assign o_valid     = r_vld[NSTG-1];
    assign o_ctl.load  = w_load;
    assign o_ctl.vld   = r_vld;

`ifndef NO_ASSERTIONS
    // Occupancy changes only by accepted input and output transactions.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(r_vld) == $past($countones(r_vld))
                + int'($past(i_valid && o_ready)) - int'($past(o_valid && i_ready))))
        else $error("pipeline occupancy does not match transactions");

    // A full pipeline under a stalled output takes no new transaction.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_ready) |-> !o_ready)
        else $error("input accepted while pipeline is full and stalled");
`endif

endmodule

### design/mpr_chan.sv
// Datapath of one color channel: mask, align, rounding numerator and an
// eight-stage restoring division by the channel maximum.
// Depends on mpr_pkg; stage enables come from mpr_ctl, configuration from mpr_cfg.
module mpr_chan
    import mpr_pkg::*;
#(
    parameter int PIXEL_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [MASK_W-1:0] i_pix,
    input  t_chan_cfg         i_cfg,
    input  t_pipe_ctl         i_ctl,
    output logic [OUT_W-1:0]  o_comp
);

    localparam int DW = (PIXEL_BITS < MASK_W) ? PIXEL_BITS : MASK_W;
    localparam int NW = DW + OUT_W;

    logic [DW-1:0]    r_pix;
    logic [DW-1:0]    r_msk;
    logic [DW-1:0]    r_val;
    logic [DW-1:0]    w_max;
    logic [NW-1:0]    n_num;
    logic [NW-1:0]    r_rem [DIV_STEPS+1];
    logic [OUT_W-1:0] r_quo [1:DIV_STEPS];

    assign w_max = i_cfg.maximum[DW-1:0];

    // Capture, mask and align the component.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[STG_PIX]) begin
            r_pix <= i_pix[DW-1:0];
        end
        if (i_ctl.load[STG_MSK]) begin
            r_msk <= r_pix & i_cfg.mask[DW-1:0];
        end
        if (i_ctl.load[STG_VAL]) begin
            r_val <= r_msk >> i_cfg.shift;
        end
    end

    // Numerator value*255 + maximum/2, formed as value*256 - value + half.
    assign n_num = ({{OUT_W{1'b0}}, r_val} << OUT_W) - {{OUT_W{1'b0}}, r_val}
                 + {{(OUT_W + 1){1'b0}}, w_max[DW-1:1]};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[STG_NUM]) begin
            r_rem[0] <= n_num;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int BITPOS = DIV_STEPS - 1 - j;
        logic [NW-1:0]    w_div;
        logic [OUT_W-1:0] w_qin;

        assign w_div = {{OUT_W{1'b0}}, w_max} << BITPOS;

        if (j == 0) begin : g_first
            assign w_qin = '0;
        end else begin : g_next
            assign w_qin = r_quo[j];
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.load[STG_DIV + j]) begin
                if (r_rem[j] >= w_div) begin
                    r_rem[j+1] <= r_rem[j] - w_div;
                    r_quo[j+1] <= {w_qin[OUT_W-2:0], 1'b1};
                end else begin
                    r_rem[j+1] <= r_rem[j];
                    r_quo[j+1] <= {w_qin[OUT_W-2:0], 1'b0};
                end
            end
        end
    end

    // A channel with no mask bits gives zero.
    assign o_comp = i_cfg.zero ? '0 : r_quo[DIV_STEPS];

`ifndef NO_ASSERTIONS
    // The numerator always yields a quotient that fits in eight bits.
    a_num_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.vld[STG_NUM] && !i_cfg.zero) |->
            (r_rem[0] < ({{OUT_W{1'b0}}, w_max} << OUT_W)))
        else $error("numerator exceeds quotient range");

    // After the last step the remainder is below the divisor.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.vld[NSTG-1] && !i_cfg.zero) |->
            (r_rem[DIV_STEPS] < {{OUT_W{1'b0}}, w_max}))
        else $error("division remainder not reduced");
`endif

endmodule

### design/masked_pixel_to_rgb888.sv
// Masked pixel to RGB888 converter.
// One packed pixel word goes in per input transaction on i_valid/o_ready with
// i_pixel_value; one result with 8-bit red, green and blue comes out per output
// transaction on o_valid/i_ready. Each channel mask is set through the APB-style
// port (red at 0x0, green at 0x4, blue at 0x8; pready is always high).
// Each component is (value*255 + maximum/2) / maximum of its masked, aligned bits;
// a zero mask gives 0.
// From input to output a pixel passes capture, mask, align, numerator, then eight
// restoring-division stages that each settle one quotient bit. Throughput is one
// pixel per cycle unless the receiver stalls; every stage has its own valid bit
// and loads whenever it is empty or its successor moves, so bubbles are squeezed
// out. When the receiver stalls the held result stays on the outputs and the
// earlier stages keep filling; o_ready drops only once all 12 stages are full.
// Reset clears every valid bit and loads the masks 0x00FF0000, 0x0000FF00 and
// 0x000000FF. Mask writes are bound on the user: masks are changed only while no
// transaction is in flight, which the block itself does not enforce.
// Depends on mpr_pkg, mpr_cfg, mpr_ctl and mpr_chan.
module masked_pixel_to_rgb888
    import mpr_pkg::*;
#(
    parameter int PIXEL_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [MASK_W-1:0] pwdata,
    output logic [MASK_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [MASK_W-1:0] i_pixel_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [OUT_W-1:0]  o_red_out,
    output logic [OUT_W-1:0]  o_green_out,
    output logic [OUT_W-1:0]  o_blue_out
);

    t_chan_cfg        w_cfg [NUM_CH];
    t_pipe_ctl        w_ctl;
    logic [OUT_W-1:0] w_comp [NUM_CH];

    // Mask registers and derived channel settings.
    mpr_cfg #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Shared stage control.
    mpr_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_ctl   (w_ctl)
    );

    // One datapath per color channel.
    for (genvar c = 0; c < NUM_CH; c++) begin : g_chan
        mpr_chan #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pix   (i_pixel_value),
            .i_cfg   (w_cfg[c]),
            .i_ctl   (w_ctl),
            .o_comp  (w_comp[c])
        );
    end

    assign o_red_out   = w_comp[0];
    assign o_green_out = w_comp[1];
    assign o_blue_out  = w_comp[2];

endmodule

### tb/masked_pixel_to_rgb888_tb.sv
// Self-checking testbench for the masked pixel to RGB888 converter.
// Drives pixels and APB mask writes, predicts each color result and checks it.
// Depends on mpr_pkg and masked_pixel_to_rgb888.
module masked_pixel_to_rgb888_tb;
    import mpr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CLK_HALF    = 5;
    localparam int         IDLE_LIMIT  = 5000;
    localparam int         DRAIN_WAIT  = 24;
    localparam int         RAND_PHASES = 8;
    localparam int         PHASE_ITEMS = 228;
    localparam int         PRINT_CAP   = 100;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    typedef struct {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } t_rgb;

    // Holds the current masks, predicts colors and checks results in order.
    class rgb888_scoreboard;
        logic [MASK_W-1:0] chan_mask[NUM_CH];
        t_rgb              expected_rgb[$];
        int                errors;

        function new();
            chan_mask[REG_RED]   = 32'h00FF_0000;
            chan_mask[REG_GREEN] = 32'h0000_FF00;
            chan_mask[REG_BLUE]  = 32'h0000_00FF;
            errors = 0;
        endfunction

        task report(string what);
            if (errors < PRINT_CAP)
                $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        // Register writes to an unused index are dropped.
        function void set_mask(logic [1:0] idx, logic [MASK_W-1:0] value);
            if (idx != REG_UNUSED)
                chan_mask[idx] = value;
        endfunction

        // Scale the masked, aligned bits of one channel to 0..255 with rounding.
        function logic [OUT_W-1:0] predict_level(logic [MASK_W-1:0] pixel,
                                                 logic [MASK_W-1:0] mask);
            longint unsigned top;
            longint unsigned val;
            longint unsigned num;
            int              sh;
            if (mask == '0)
                return '0;
            sh = 0;
            while (!mask[sh])
                sh++;
            top = 64'(mask >> sh);
            val = 64'((pixel & mask) >> sh);
            num = (val * 255 + top / 2) / top;
            if (num > 255)
                num = 255;
            return num[OUT_W-1:0];
        endfunction

        function void note_pixel(logic [MASK_W-1:0] pixel);
            t_rgb c;
            c.red   = predict_level(pixel, chan_mask[REG_RED]);
            c.green = predict_level(pixel, chan_mask[REG_GREEN]);
            c.blue  = predict_level(pixel, chan_mask[REG_BLUE]);
            expected_rgb.push_back(c);
        endfunction

        task check_result(logic [OUT_W-1:0] r, logic [OUT_W-1:0] g, logic [OUT_W-1:0] b);
            t_rgb c;
            if (expected_rgb.size() == 0) begin
                report($sformatf("result %h/%h/%h with no pixel pending", r, g, b));
                return;
            end
            c = expected_rgb.pop_front();
            if (r !== c.red)
                report($sformatf("red got %h want %h", r, c.red));
            if (g !== c.green)
                report($sformatf("green got %h want %h", g, c.green));
            if (b !== c.blue)
                report($sformatf("blue got %h want %h", b, c.blue));
        endtask

        function int pending();
            return expected_rgb.size();
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [MASK_W-1:0] pwdata        = '0;
    logic [MASK_W-1:0] prdata;
    logic              pready;
    logic              i_valid       = 1'b0;
    logic              o_ready;
    logic [MASK_W-1:0] i_pixel_value = '0;
    logic              o_valid;
    logic              i_ready       = 1'b0;
    logic [OUT_W-1:0]  o_red_out;
    logic [OUT_W-1:0]  o_green_out;
    logic [OUT_W-1:0]  o_blue_out;

    rgb888_scoreboard sb = new();
    bit               tx_calm     = 1'b0;
    bit               rx_calm     = 1'b0;
    int               idle_cycles = 0;

    masked_pixel_to_rgb888 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_value (i_pixel_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Gap lengths: mostly none or short, a few long.
    function int gap_len(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Random mask of one of several shapes: empty, full, single bit, runs, gaps.
    function logic [MASK_W-1:0] rand_mask();
        logic [63:0] run;
        int          lo;
        int          w;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(0, 31);
            3: begin
                lo  = $urandom_range(0, 31);
                w   = $urandom_range(1, 32 - lo);
                run = ((64'h1 << w) - 1) << lo;
                return run[MASK_W-1:0];
            end
            4: return $urandom;
            5: return $urandom & $urandom;
            6: begin
                case ($urandom_range(0, 5))
                    0: return 32'h0000_F800;
                    1: return 32'h0000_07E0;
                    2: return 32'h0000_001F;
                    3: return 32'h00FF_0000;
                    4: return 32'h0000_FF00;
                    default: return 32'h0000_00FF;
                endcase
            end
            default: begin
                lo  = $urandom_range(0, 31);
                w   = $urandom_range(1, 8);
                run = ((64'h1 << w) - 1) << lo;
                return run[MASK_W-1:0];
            end
        endcase
    endfunction

    function logic [MASK_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return sb.chan_mask[$urandom_range(0, NUM_CH - 1)];
            default: return $urandom;
        endcase
    endfunction

    // One APB write: setup phase, access phase, then psel is released.
    task apb_write(logic [1:0] idx, logic [MASK_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_mask(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // One APB read, compared with the mask the scoreboard holds.
    task apb_read_check(logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== sb.chan_mask[idx])
            sb.report($sformatf("mask reg %0d read %h want %h", idx, prdata,
                                sb.chan_mask[idx]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Change all masks while the pipeline is empty, poke the unused index, read back.
    task set_masks(logic [MASK_W-1:0] r, logic [MASK_W-1:0] g, logic [MASK_W-1:0] b);
        apb_write(REG_RED, r);
        apb_write(REG_GREEN, g);
        apb_write(REG_BLUE, b);
        apb_write(REG_UNUSED, $urandom);
        apb_read_check(REG_RED);
        apb_read_check(REG_GREEN);
        apb_read_check(REG_BLUE);
    endtask

    // Offer one pixel and hold it until the transaction completes.
    task send_pixel(logic [MASK_W-1:0] pixel);
        int gap;
        i_valid       <= 1'b1;
        i_pixel_value <= pixel;
        do @(posedge i_clk); while (!o_ready);
        sb.note_pixel(pixel);
        gap = gap_len(tx_calm);
        if (gap > 0) begin
            i_valid       <= 1'b0;
            i_pixel_value <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task stop_pixels();
        i_valid <= 1'b0;
    endtask

    task wait_drained();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task send_random(int n);
        repeat (n) send_pixel(rand_pixel());
    endtask

    // Receiver: bursts of ready with random stalls between them.
    initial begin : result_sink
        int len;
        @(posedge i_clk iff i_rst_n);
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            len = gap_len(rx_calm);
            if (len > 0) begin
                i_ready <= 1'b0;
                repeat (len) @(posedge i_clk);
            end
        end
    end

    // Every result transaction is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_red_out, o_green_out, o_blue_out);
    end

    // Count cycles with no transaction on any port.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("** masked_pixel_to_rgb888: FAILED **");
        $finish;
    end

    initial begin : stimulus
        static logic [MASK_W-1:0] reset_px[10] = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF,
            32'h0080_8080, 32'h007F_7F7F, 32'h0001_0101, 32'h00FE_FEFE, 32'hFF00_0000};
        static logic [MASK_W-1:0] wide_px[7] = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001};
        static logic [MASK_W-1:0] gap_px[8] = '{
            32'h0000_0001, 32'h0000_F0F0, 32'h0000_A050, 32'hFFFF_0000,
            32'h8000_8000, 32'h1234_5678, 32'h0000_FFFF, 32'h0000_7FFF};
        int mode;

        // Hold synchronous reset, then release it.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset masks read back and the standard 8:8:8 layout.
        apb_read_check(REG_RED);
        apb_read_check(REG_GREEN);
        apb_read_check(REG_BLUE);
        foreach (reset_px[k])
            send_pixel(reset_px[k]);
        stop_pixels();
        wait_drained();

        // Zero mask, full-width mask and a single top bit.
        set_masks(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
        foreach (wide_px[k])
            send_pixel(wide_px[k]);
        stop_pixels();
        wait_drained();

        // Single low bit, a mask with holes and a wide upper run.
        set_masks(32'h0000_0001, 32'h0000_F0F0, 32'hFFFF_0000);
        foreach (gap_px[k])
            send_pixel(gap_px[k]);
        stop_pixels();
        wait_drained();

        // Random phases, each with fresh masks and its own idling mix.
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            mode    = $urandom_range(0, 3);
            tx_calm = (phase == 1) || (mode == 0);
            rx_calm = (phase == 1) || (mode == 1);
            if (phase == 2)
                set_masks(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF);
            else if (phase == 5)
                set_masks(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
            else
                set_masks(rand_mask(), rand_mask(), rand_mask());
            if (phase == 3) begin
                // Sender holds off until every result is back, then resumes.
                send_random(PHASE_ITEMS / 2);
                stop_pixels();
                wait_drained();
                send_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            end else begin
                send_random(PHASE_ITEMS);
            end
            stop_pixels();
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** masked_pixel_to_rgb888: PASSED **");
        else
            $display("** masked_pixel_to_rgb888: FAILED **");
        $finish;
    end

endmodule
